FILE: src/rts_pkg.sv
// Shared types and constants for the real-time task scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package rts_pkg;

    localparam int SLOT_W  = 4;
    localparam int DATA_W  = 32;
    localparam int APB_AW  = 3;

    // command field codes
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // policy_mode codes
    localparam logic POL_EDF = 1'b0;
    localparam logic POL_RM  = 1'b1;

    // register index (word address bit) of policy_mode
    localparam logic REG_POLICY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REL,
        ST_CHG,
        ST_SCAN,
        ST_DONE
    } state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              rel_en;
        logic              chg_en;
        logic              op;
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic              run_valid;
        logic [SLOT_W-1:0] run_slot;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] budget;
        logic [DATA_W-1:0] deadline;
        logic [DATA_W-1:0] time_now;
    } cmd_t;

    // selection token passed along the chain
    typedef struct packed {
        logic              found;
        logic              spent;
        logic              missed;
        logic [DATA_W-1:0] key;
    } tok_t;

endpackage

`default_nettype wire

FILE: src/rts_cell.sv
// One task slot: holds its timing state, applies register/release/charge
// and merges its candidate into the selection token. Depends on rts_pkg.
`default_nettype none

module rts_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rts_pkg::cmd_t cmd,
    input  wire rts_pkg::tok_t tok_in,
    input  wire logic [IW-1:0] idx_in,
    output rts_pkg::tok_t      tok_out,
    output logic [IW-1:0]      idx_out
);
    import rts_pkg::*;

    localparam bit HAS_SLOT = (IDX < (1 << SLOT_W));
    localparam logic [31:0] IDX_L = 32'(IDX);
    localparam logic [SLOT_W-1:0] MY_SLOT = IDX_L[SLOT_W-1:0];
    localparam logic [IW-1:0] MY_IDX = IDX_L[IW-1:0];

    logic              valid_reg, valid_next;
    logic              ready_reg, ready_next;
    logic              spent_reg, spent_next;
    logic              missed_reg, missed_next;
    logic [DATA_W-1:0] period_reg, period_next;
    logic [DATA_W-1:0] budget_reg, budget_next;
    logic [DATA_W-1:0] used_reg, used_next;
    logic [DATA_W-1:0] deadline_reg, deadline_next;
    logic [DATA_W-1:0] release_reg, release_next;
    tok_t              tok_reg, tok_next;
    logic [IW-1:0]     idx_reg, idx_next;

    logic              slot_hit, run_hit;
    logic [DATA_W-1:0] used_inc, key;
    logic              take;

    assign slot_hit = HAS_SLOT && (cmd.slot == MY_SLOT);
    assign run_hit  = HAS_SLOT && cmd.run_valid && (cmd.run_slot == MY_SLOT);
    assign used_inc = used_reg + 32'd1;

    always_comb
    begin
        valid_next    = valid_reg;
        ready_next    = ready_reg;
        spent_next    = spent_reg;
        missed_next   = missed_reg;
        period_next   = period_reg;
        budget_next   = budget_reg;
        used_next     = used_reg;
        deadline_next = deadline_reg;
        release_next  = release_reg;
        if (cmd.rel_en)
        begin
            spent_next  = 1'b0;
            missed_next = 1'b0;
            if (cmd.op == CMD_REGISTER)
            begin
                if (slot_hit)
                begin
                    valid_next    = 1'b1;
                    ready_next    = 1'b1;
                    period_next   = cmd.period;
                    budget_next   = cmd.budget;
                    used_next     = '0;
                    deadline_next = cmd.deadline;
                    release_next  = cmd.time_now + cmd.period;
                end
            end
            else if (valid_reg && (cmd.time_now >= release_reg))
            begin
                release_next  = release_reg + period_reg;
                deadline_next = cmd.time_now + period_reg;
                used_next     = '0;
                ready_next    = 1'b1;
            end
        end
        if (cmd.chg_en && (cmd.op == CMD_TICK) && run_hit && valid_reg)
        begin
            used_next = used_inc;
            if (used_inc >= budget_reg)
            begin
                ready_next = 1'b0;
                spent_next = 1'b1;
            end
            if (cmd.time_now > deadline_reg)
                missed_next = 1'b1;
        end
    end

    // token merge: strict less-than keeps ties on the lower slot
    always_comb
    begin
        key  = (cmd.mode == POL_RM) ? period_reg : deadline_reg;
        take = valid_reg && ready_reg && (!tok_in.found || (key < tok_in.key));
        tok_next        = tok_in;
        idx_next        = idx_in;
        tok_next.spent  = tok_in.spent | spent_reg;
        tok_next.missed = tok_in.missed | missed_reg;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.key   = key;
            idx_next       = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            ready_reg  <= 1'b0;
            spent_reg  <= 1'b0;
            missed_reg <= 1'b0;
            tok_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            ready_reg  <= ready_next;
            spent_reg  <= spent_next;
            missed_reg <= missed_next;
            tok_reg    <= tok_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg   <= period_next;
        budget_reg   <= budget_next;
        used_reg     <= used_next;
        deadline_reg <= deadline_next;
        release_reg  <= release_next;
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

`default_nettype wire

FILE: src/realtime_task_scheduler_top.sv
// Each transaction passes through release and charge, then a scan while the selection
// token ripples down the cell chain, then a load of the output register; the load
// waits while a held result is stalled. A new item is taken once the previous one is
// loaded, while the previous result may still wait in the output register.
// Reset: asynchronous, active low; clears time, miss count, policy and all slots.
// Top level of the real-time task scheduler; depends on rts_pkg and rts_cell.
`default_nettype none

module realtime_task_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rts_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       command,
    input  wire logic [rts_pkg::SLOT_W-1:0] slot,
    input  wire logic [31:0]                task_period,
    input  wire logic [31:0]                task_budget,
    input  wire logic [31:0]                initial_deadline,
    input  wire logic                       running_valid,
    input  wire logic [rts_pkg::SLOT_W-1:0] running_slot,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            pick_valid,
    output logic [rts_pkg::SLOT_W-1:0]      pick_slot,
    output logic                            budget_spent,
    output logic                            deadline_missed,
    output logic [31:0]                     missed_total,
    output logic [31:0]                     tick_count
);
    import rts_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] SCAN_LAST = CW'(MAX_TASKS - 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              mode_reg;
    logic [DATA_W-1:0] time_reg, miss_reg;
    logic              op_reg, run_valid_reg;
    logic [SLOT_W-1:0] slot_reg, run_slot_reg;
    logic [DATA_W-1:0] period_reg, budget_reg, deadline_reg;

    logic              out_valid_reg;
    logic              pick_valid_reg, spent_reg, missed_reg;
    logic [SLOT_W-1:0] pick_slot_reg;
    logic [DATA_W-1:0] total_reg, ctime_reg;

    logic in_acc, out_acc, load_out, cfg_wr;
    cmd_t cmd;

    tok_t          tok_w [MAX_TASKS+1];
    logic [IW-1:0] idx_w [MAX_TASKS+1];

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_POLICY);
    assign prdata   = (paddr[2] == REG_POLICY) ? {31'd0, mode_reg} : 32'd0;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;

    always_comb
    begin
        cmd.rel_en    = (state_reg == ST_REL);
        cmd.chg_en    = (state_reg == ST_CHG);
        cmd.op        = op_reg;
        cmd.mode      = mode_reg;
        cmd.slot      = slot_reg;
        cmd.run_valid = run_valid_reg;
        cmd.run_slot  = run_slot_reg;
        cmd.period    = period_reg;
        cmd.budget    = budget_reg;
        cmd.deadline  = deadline_reg;
        cmd.time_now  = time_reg;
    end

    assign tok_w[0] = '0;
    assign idx_w[0] = '0;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        rts_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .tok_in  (tok_w[i]),
            .idx_in  (idx_w[i]),
            .tok_out (tok_w[i+1]),
            .idx_out (idx_w[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_REL;
            end
            ST_REL:
                state_next = ST_CHG;
            ST_CHG:
            begin
                state_next = ST_SCAN;
                cnt_next   = '0;
            end
            ST_SCAN:
            begin
                if (cnt_reg == SCAN_LAST)
                    state_next = ST_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mode_reg      <= POL_EDF;
            time_reg      <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr)
                mode_reg <= pwdata[0];
            if (in_acc && (command == CMD_TICK))
                time_reg <= time_reg + 32'd1;
            if (load_out && tok_w[MAX_TASKS].missed)
                miss_reg <= miss_reg + 32'd1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg        <= command;
            slot_reg      <= slot;
            period_reg    <= task_period;
            budget_reg    <= task_budget;
            deadline_reg  <= initial_deadline;
            run_valid_reg <= running_valid;
            run_slot_reg  <= running_slot;
        end
        if (load_out)
        begin
            pick_valid_reg <= tok_w[MAX_TASKS].found;
            pick_slot_reg  <= SLOT_W'(idx_w[MAX_TASKS]);
            spent_reg      <= tok_w[MAX_TASKS].spent;
            missed_reg     <= tok_w[MAX_TASKS].missed;
            total_reg      <= miss_reg + {31'd0, tok_w[MAX_TASKS].missed};
            ctime_reg      <= time_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pick_valid      = pick_valid_reg;
    assign pick_slot       = pick_slot_reg;
    assign budget_spent    = spent_reg;
    assign deadline_missed = missed_reg;
    assign missed_total    = total_reg;
    assign tick_count      = ctime_reg;

endmodule

`default_nettype wire

FILE: src/rts_checker.sv
// Port-level checks for the real-time task scheduler, bound to the top level.
// Depends on rts_pkg and realtime_task_scheduler_top.
`default_nettype none

module rts_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic                       pick_valid,
    input wire logic [rts_pkg::SLOT_W-1:0] pick_slot,
    input wire logic                       budget_spent,
    input wire logic                       deadline_missed
);
    import rts_pkg::*;

    // a transaction keeps the block busy on the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // with no ready task the reported slot is zero
    a_empty_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pick_valid) |-> (pick_slot == '0))
        else $error("pick_slot nonzero without a ready task");

    // a new result only appears after a busy period
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without preceding work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pick_slot)
            && $stable(pick_valid) && $stable(budget_spent) && $stable(deadline_missed)))
        else $error("stalled result changed");

endmodule

bind realtime_task_scheduler_top rts_checker u_rts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pick_valid      (pick_valid),
    .pick_slot       (pick_slot),
    .budget_spent    (budget_spent),
    .deadline_missed (deadline_missed)
);

`default_nettype wire
